@@ rtl/core/kbsc_pkg.sv @@
`timescale 1ns / 1ps

package kbsc_pkg;

  // Block geometry
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned IdxW       = $clog2(BlockBytes);
  localparam int unsigned KeyWords   = 8;
  localparam int unsigned KeyIdxW    = $clog2(KeyWords);
  localparam int unsigned GenWords   = 4;

  // Generator constants
  localparam int unsigned GenShift   = 17;
  localparam int unsigned GenRot     = 45;
  localparam int unsigned OutRot     = 23;
  localparam int unsigned MinOnes    = 4;

  // Request opcodes
  localparam logic [1:0] OpEncrypt = 2'd0;
  localparam logic [1:0] OpDecrypt = 2'd1;
  localparam logic [1:0] OpReseed  = 2'd2;

  typedef logic [KeyWords-1:0][63:0] key_t;
  typedef logic [GenWords-1:0][63:0] gen_t;

  // Reverse the bit order of one byte
  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int b = 0; b < 8; b++) begin
      r[7-b] = v[b];
    end
    return r;
  endfunction

  // Count set bits of one byte
  function automatic logic [3:0] popcnt8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < 8; b++) begin
      n = n + {3'b000, v[b]};
    end
    return n;
  endfunction

  // Low byte of the xoshiro256++ output: rotl(g0 + g3, 23) + g0
  function automatic logic [7:0] gen_out_byte(input gen_t g);
    logic [64-OutRot+7:0] s;
    s = g[0][64-OutRot+7:0] + g[3][64-OutRot+7:0];
    return s[64-OutRot+7:64-OutRot] + g[0][7:0];
  endfunction

  // Advance the generator by one step
  function automatic gen_t gen_step(input gen_t g);
    gen_t n;
    logic [63:0] t;
    t    = g[1] << GenShift;
    n[2] = g[2] ^ g[0];
    n[3] = g[3] ^ g[1];
    n[1] = g[1] ^ n[2];
    n[0] = g[0] ^ n[3];
    n[2] = n[2] ^ t;
    n[3] = {n[3][63-GenRot:0], n[3][63:64-GenRot]};
    return n;
  endfunction

  // Permutation entry: key byte i, reduced to a block index
  function automatic logic [IdxW-1:0] perm_idx(input key_t k, input logic [IdxW-1:0] i);
    logic [7:0] kb;
    kb = k[i[IdxW-1:3]][{i[2:0], 3'b000} +: 8];
    return kb[IdxW-1:0];
  endfunction

endpackage

@@ rtl/core/keyed_block_scramble_cipher_unit.sv @@
`timescale 1ns / 1ps

// A data byte is written into the block store; the byte that fills a block starts a flush
// that emits 64 results, and no new request is accepted until the flush ends (busy_o).
// Reset: clears keys, generator state, block position and control; the receiver
// cannot stall, so each result is shown for exactly one cycle under out_valid_o.
module keyed_block_scramble_cipher_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                opcode_i,
  input  logic [7:0]                in_byte_i,
  input  logic                      cfg_we_i,
  input  logic [kbsc_pkg::KeyIdxW-1:0] cfg_idx_i,
  input  logic [63:0]               cfg_wdata_i,
  output logic                      out_valid_o,
  output logic [7:0]                out_byte_o,
  output logic                      out_last_o
);
  import kbsc_pkg::*;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StEncRd = 8'b0000_0010,
    StEncKs = 8'b0000_0100,
    StEncOut = 8'b0000_1000,
    StDecA  = 8'b0001_0000,
    StDecAw = 8'b0010_0000,
    StDecRd = 8'b0100_0000,
    StDecKs = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  key_t            key_q;
  gen_t            gen_q, gen_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] idx_inc;
  logic            idx_last;

  // Memories
  logic [7:0]      store_mem [BlockBytes];
  logic [7:0]      tmp_mem   [BlockBytes];
  logic            store_we, store_re;
  logic [IdxW-1:0] store_raddr;
  logic [7:0]      store_rdata_q;
  logic            tmp_we, tmp_re;
  logic [IdxW-1:0] tmp_waddr, tmp_raddr;
  logic [7:0]      tmp_wdata, tmp_rdata_q;

  // Written marks for the decrypt scatter
  logic [BlockBytes-1:0] vld_q, vld_d;
  logic                  vld_rd_q, vld_rd_d;

  // Scatter write pipeline and encrypt read pipeline
  logic            wr_pend_q, wr_pend_d;
  logic [IdxW-1:0] wr_idx_q;
  logic            enc_pend_q, enc_pend_d;
  logic            enc_last_q, enc_last_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_last_q, out_last_d;

  // Keystream candidate
  logic            gen_zero, ks_ok, ks_draw;
  logic [7:0]      ks_cand, ks_byte;
  logic            accept;

  assign accept   = start_i && (state_q == StIdle);
  assign idx_inc  = idx_q + 1'b1;
  assign idx_last = (idx_q == IdxW'(BlockBytes - 1));

  assign gen_zero = ~|gen_q;
  assign ks_cand  = gen_out_byte(gen_q);
  assign ks_ok    = gen_zero || (popcnt8(ks_cand) >= 4'(MinOnes));
  assign ks_byte  = gen_zero ? 8'h00 : ks_cand;
  assign ks_draw  = (state_q == StEncKs) || (state_q == StDecKs);

  // Sequence the fill, the reseed and both flush modes
  always_comb begin
    state_d     = state_q;
    gen_d       = gen_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    vld_d       = vld_q;
    vld_rd_d    = vld_rd_q;
    store_we    = 1'b0;
    store_re    = 1'b0;
    store_raddr = idx_q;
    tmp_we      = 1'b0;
    tmp_re      = 1'b0;
    tmp_waddr   = idx_q;
    tmp_raddr   = idx_q;
    tmp_wdata   = '0;
    wr_pend_d   = 1'b0;
    enc_pend_d  = 1'b0;
    enc_last_d  = 1'b0;
    out_valid_d = enc_pend_q;
    out_byte_d  = tmp_rdata_q;
    out_last_d  = enc_pend_q && enc_last_q;

    // Advance the generator on every draw cycle unless it is all zero
    if (ks_draw && !gen_zero) begin
      gen_d = gen_step(gen_q);
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (opcode_i == OpReseed) begin
            gen_d = key_q[GenWords-1:0];
            pos_d = '0;
          end else if (opcode_i == OpEncrypt || opcode_i == OpDecrypt) begin
            store_we = 1'b1;
            pos_d    = pos_q + 1'b1;
            idx_d    = '0;
            if (pos_q == IdxW'(BlockBytes - 1)) begin
              if (opcode_i == OpEncrypt) begin
                state_d = StEncRd;
              end else begin
                vld_d   = '0;
                state_d = StDecA;
              end
            end
          end
        end
      end
      StEncRd: begin
        store_re = 1'b1;
        state_d  = StEncKs;
      end
      StEncKs: begin
        if (ks_ok) begin
          tmp_we    = 1'b1;
          tmp_wdata = bit_rev8(store_rdata_q ^ ks_byte);
          if (idx_last) begin
            idx_d   = '0;
            state_d = StEncOut;
          end else begin
            idx_d       = idx_inc;
            store_re    = 1'b1;
            store_raddr = idx_inc;
          end
        end
      end
      StEncOut: begin
        tmp_re     = 1'b1;
        tmp_raddr  = perm_idx(key_q, idx_q);
        enc_pend_d = 1'b1;
        enc_last_d = idx_last;
        idx_d      = idx_inc;
        if (idx_last) begin
          state_d = StIdle;
        end
      end
      StDecA: begin
        store_re  = 1'b1;
        wr_pend_d = 1'b1;
        idx_d     = idx_inc;
        if (idx_last) begin
          state_d = StDecAw;
        end
      end
      StDecAw: begin
        idx_d   = '0;
        state_d = StDecRd;
      end
      StDecRd: begin
        tmp_re   = 1'b1;
        vld_rd_d = vld_q[idx_q];
        state_d  = StDecKs;
      end
      StDecKs: begin
        if (ks_ok) begin
          out_valid_d = 1'b1;
          out_byte_d  = bit_rev8(vld_rd_q ? tmp_rdata_q : 8'h00) ^ ks_byte;
          out_last_d  = idx_last;
          if (idx_last) begin
            idx_d   = '0;
            state_d = StIdle;
          end else begin
            idx_d     = idx_inc;
            tmp_re    = 1'b1;
            tmp_raddr = idx_inc;
            vld_rd_d  = vld_q[idx_inc];
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // Drop the scattered byte into its permuted slot
    if (wr_pend_q) begin
      tmp_we               = 1'b1;
      tmp_waddr            = perm_idx(key_q, wr_idx_q);
      tmp_wdata            = store_rdata_q;
      vld_d[tmp_waddr]     = 1'b1;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      key_q       <= '0;
      gen_q       <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
      wr_pend_q   <= 1'b0;
      wr_idx_q    <= '0;
      enc_pend_q  <= 1'b0;
      enc_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      vld_q       <= vld_d;
      vld_rd_q    <= vld_rd_d;
      wr_pend_q   <= wr_pend_d;
      wr_idx_q    <= idx_q;
      enc_pend_q  <= enc_pend_d;
      enc_last_q  <= enc_last_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
      if (cfg_we_i) begin
        key_q[cfg_idx_i] <= cfg_wdata_i;
      end
    end
  end

  // Raw block store
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[pos_q] <= in_byte_i;
    end
    if (store_re) begin
      store_rdata_q <= store_mem[store_raddr];
    end
  end

  // Transformed block store
  always_ff @(posedge clk_i) begin
    if (tmp_we) begin
      tmp_mem[tmp_waddr] <= tmp_wdata;
    end
    if (tmp_re) begin
      tmp_rdata_q <= tmp_mem[tmp_raddr];
    end
  end

  assign busy_o      = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // A transformed-store write never collides with a read of the same entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tmp_we && tmp_re && (tmp_waddr == tmp_raddr)))
    else $error("tmp store read and write hit the same entry");

  // A zero generator stays zero while drawing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ks_draw && gen_zero) |=> gen_zero)
    else $error("zero generator left its fixed point");

  // The last byte of a block is followed by a quiet cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |=> !out_valid_o)
    else $error("result after last byte of block");

endmodule
